>>> rtl/cubic_basemul_montgomery_unit_assert.svh
// Assertion macros for the cubic base multiplier.
`ifndef CUBIC_BASEMUL_MONTGOMERY_UNIT_ASSERT_SVH
`define CUBIC_BASEMUL_MONTGOMERY_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cbm assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CBM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cbm assertion failed");

`endif

>>> rtl/cbm_pkg.sv
// Package with constants and Montgomery reduction helpers for the cubic base multiplier.
`timescale 1ns / 1ps

package cbm_pkg;

  localparam int unsigned CoeffW = 16;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned InW    = 7 * CoeffW;
  localparam int unsigned OutW   = 3 * CoeffW;
  localparam int unsigned NumStages = 8;

  localparam logic signed [CoeffW-1:0] QMod       = 16'sd3457;
  localparam logic        [CoeffW-1:0] MontNegQinv = 16'd52607;

  typedef logic signed [CoeffW-1:0] coeff_t;
  typedef logic signed [ProdW-1:0]  prod_t;

  function automatic coeff_t mont_m(input prod_t t);
    logic [ProdW-1:0] x;
    x = ProdW'(t[CoeffW-1:0]) * ProdW'(MontNegQinv);
    return coeff_t'(x[CoeffW-1:0]);
  endfunction

  function automatic coeff_t mont_r(input prod_t t, input coeff_t m);
    prod_t mq;
    prod_t s;
    mq = prod_t'(m) * prod_t'(QMod);
    s  = t + mq;
    return coeff_t'(s[ProdW-1:CoeffW]);
  endfunction

endpackage

>>> rtl/cubic_basemul_montgomery_unit.sv
// Top level: pipelined base multiplication modulo x^3 - zeta with Montgomery reduction.
// Usage:
//   Slave stream s_axis carries one item per handshake: a0, a1, a2, b0, b1, b2 and
//   zeta, each a signed 16-bit value. Master stream m_axis returns one item per
//   input item: the three coefficients of the reduced product, in input order.
//   The datapath is an eight-stage pipeline: nine products, sums, quotient
//   multiply, first reduction, zeta products, final sums, quotient multiply,
//   final reduction. Throughput is one item per cycle while m_axis_tready is high.
//   Each stage has its own valid bit and loads when empty or when the stage
//   after it moves, so bubbles close up and s_axis_tready stays high while any
//   stage is empty, even if a finished item waits at the output.
//   When the receiver holds m_axis_tready low, items back up stage by stage
//   and none is lost or repeated; s_axis_tready falls once all stages are full.
//   Reset clears all valid bits; the data registers are not reset.
`timescale 1ns / 1ps

module cubic_basemul_montgomery_unit
  import cbm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // a_coeff_0, a_coeff_1, a_coeff_2, b_coeff_0, b_coeff_1, b_coeff_2, zeta_twiddle
  input  logic [InW-1:0]  s_axis_tdata,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  // prod_coeff_0, prod_coeff_1, prod_coeff_2
  output logic [OutW-1:0] m_axis_tdata
);

`include "cubic_basemul_montgomery_unit_assert.svh"

  logic [NumStages-1:0] vld_q, vld_d, rdy;

  coeff_t a0, a1, a2, b0, b1, b2, zt;

  assign a0 = coeff_t'(s_axis_tdata[0*CoeffW +: CoeffW]);
  assign a1 = coeff_t'(s_axis_tdata[1*CoeffW +: CoeffW]);
  assign a2 = coeff_t'(s_axis_tdata[2*CoeffW +: CoeffW]);
  assign b0 = coeff_t'(s_axis_tdata[3*CoeffW +: CoeffW]);
  assign b1 = coeff_t'(s_axis_tdata[4*CoeffW +: CoeffW]);
  assign b2 = coeff_t'(s_axis_tdata[5*CoeffW +: CoeffW]);
  assign zt = coeff_t'(s_axis_tdata[6*CoeffW +: CoeffW]);

  always_comb begin
    rdy[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d = vld_q;
    if (rdy[0]) begin
      vld_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (rdy[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  // stage 1: nine products
  prod_t  p21_q, p12_q, p22_q, p00_q, p01_q, p10_q, p20_q, p11_q, p02_q;
  coeff_t z1_q;
  // stage 2: sums
  prod_t  t0_2_q, t1_2_q, s2_2_q, l0_2_q, l1_2_q;
  coeff_t z2_q;
  // stage 3: quotients
  coeff_t m0_3_q, m1_3_q, m2_3_q, z3_q;
  prod_t  t0_3_q, t1_3_q, s2_3_q, l0_3_q, l1_3_q;
  // stage 4: first reduction
  coeff_t r0_4_q, r1_4_q, c2_4_q, z4_q;
  prod_t  l0_4_q, l1_4_q;
  // stage 5: zeta products
  prod_t  pz0_5_q, pz1_5_q, l0_5_q, l1_5_q;
  coeff_t c2_5_q;
  // stage 6: final sums
  prod_t  s0_6_q, s1_6_q;
  coeff_t c2_6_q;
  // stage 7: quotients
  coeff_t m0_7_q, m1_7_q, c2_7_q;
  prod_t  s0_7_q, s1_7_q;
  // stage 8: outputs
  coeff_t c0_8_q, c1_8_q, c2_8_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      p21_q <= prod_t'(a2) * prod_t'(b1);
      p12_q <= prod_t'(a1) * prod_t'(b2);
      p22_q <= prod_t'(a2) * prod_t'(b2);
      p00_q <= prod_t'(a0) * prod_t'(b0);
      p01_q <= prod_t'(a0) * prod_t'(b1);
      p10_q <= prod_t'(a1) * prod_t'(b0);
      p20_q <= prod_t'(a2) * prod_t'(b0);
      p11_q <= prod_t'(a1) * prod_t'(b1);
      p02_q <= prod_t'(a0) * prod_t'(b2);
      z1_q  <= zt;
    end
    if (rdy[1]) begin
      t0_2_q <= p21_q + p12_q;
      t1_2_q <= p22_q;
      s2_2_q <= p20_q + p11_q + p02_q;
      l0_2_q <= p00_q;
      l1_2_q <= p01_q + p10_q;
      z2_q   <= z1_q;
    end
    if (rdy[2]) begin
      m0_3_q <= mont_m(t0_2_q);
      m1_3_q <= mont_m(t1_2_q);
      m2_3_q <= mont_m(s2_2_q);
      t0_3_q <= t0_2_q;
      t1_3_q <= t1_2_q;
      s2_3_q <= s2_2_q;
      l0_3_q <= l0_2_q;
      l1_3_q <= l1_2_q;
      z3_q   <= z2_q;
    end
    if (rdy[3]) begin
      r0_4_q <= mont_r(t0_3_q, m0_3_q);
      r1_4_q <= mont_r(t1_3_q, m1_3_q);
      c2_4_q <= mont_r(s2_3_q, m2_3_q);
      l0_4_q <= l0_3_q;
      l1_4_q <= l1_3_q;
      z4_q   <= z3_q;
    end
    if (rdy[4]) begin
      pz0_5_q <= prod_t'(r0_4_q) * prod_t'(z4_q);
      pz1_5_q <= prod_t'(r1_4_q) * prod_t'(z4_q);
      l0_5_q  <= l0_4_q;
      l1_5_q  <= l1_4_q;
      c2_5_q  <= c2_4_q;
    end
    if (rdy[5]) begin
      s0_6_q <= pz0_5_q + l0_5_q;
      s1_6_q <= pz1_5_q + l1_5_q;
      c2_6_q <= c2_5_q;
    end
    if (rdy[6]) begin
      m0_7_q <= mont_m(s0_6_q);
      m1_7_q <= mont_m(s1_6_q);
      s0_7_q <= s0_6_q;
      s1_7_q <= s1_6_q;
      c2_7_q <= c2_6_q;
    end
    if (rdy[7]) begin
      c0_8_q <= mont_r(s0_7_q, m0_7_q);
      c1_8_q <= mont_r(s1_7_q, m1_7_q);
      c2_8_q <= c2_7_q;
    end
  end

  assign m_axis_tdata = {c2_8_q, c1_8_q, c0_8_q};

  `CBM_ASSERT_NXT(a_accept_fills, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, vld_q[0])
  `CBM_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !vld_q[0], s_axis_tready)
  `CBM_ASSERT_NXT(a_mid_hold, clk_i, rst_ni, vld_q[3] && !rdy[4], vld_q[3] && $stable(r0_4_q))
  `CBM_ASSERT_IMP(a_full_stall, clk_i, rst_ni, (&vld_q) && !m_axis_tready, !s_axis_tready)

endmodule
